// ===== hw/rtl/ddo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the odometry integrator
// Request formats, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

    typedef struct packed {
        logic signed [15:0] rpm_left;
        logic signed [15:0] rpm_right;
        logic        [19:0] step_time;
        logic signed [15:0] gyro_rate;
    } tick_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [19:0] heading;
        logic signed [31:0] speed_linear;
        logic signed [19:0] turn_step;
        logic               stationary;
    } pose_t;

    localparam int ANGLE_LIMIT     = 411774;
    localparam int TWO_PI_Q        = 411775;
    localparam int PI_Q            = 205887;
    localparam int HALF_PI_Q       = 102944;
    localparam int CORDIC_INV_GAIN = 652032874;
    localparam int GYRO_DIV        = 62500;
    localparam int SPEED_MUL       = 1000000;
    localparam int WORD_MAX        = 2147483647;

    // gyro turn: |t * rate| / 62500 as (|t * rate| >> 2) * ceil(2^46 / 15625) >> 46
    localparam logic [36:0] GYRO_SAT_MAG = 37'd25735937500;
    localparam logic [33:0] GYRO_RECIP   = 34'd4503599628;
    localparam int          GYRO_RSH     = 46;

    localparam int MUL_W     = 34;
    localparam int CORD_W    = 34;
    localparam int DIV_NUM_W = 59;
    localparam int DIV_DEN_W = 28;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
        logic signed [31:0] v;
        unique case (idx)
            5'd0:  v = 32'sd843314857;
            5'd1:  v = 32'sd497837829;
            5'd2:  v = 32'sd263043837;
            5'd3:  v = 32'sd133525159;
            5'd4:  v = 32'sd67021687;
            5'd5:  v = 32'sd33543516;
            5'd6:  v = 32'sd16775851;
            5'd7:  v = 32'sd8388437;
            5'd8:  v = 32'sd4194283;
            5'd9:  v = 32'sd2097149;
            5'd10: v = 32'sd1048576;
            5'd11: v = 32'sd524288;
            5'd12: v = 32'sd262144;
            5'd13: v = 32'sd131072;
            5'd14: v = 32'sd65536;
            5'd15: v = 32'sd32768;
            5'd16: v = 32'sd16384;
            5'd17: v = 32'sd8192;
            5'd18: v = 32'sd4096;
            5'd19: v = 32'sd2048;
            5'd20: v = 32'sd1024;
            5'd21: v = 32'sd512;
            5'd22: v = 32'sd256;
            5'd23: v = 32'sd128;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/ddo_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_mul: shared signed multiplier
// One signed multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module ddo_mul (
    input  logic                                clk,
    input  logic signed [ddo_pkg::MUL_W-1:0]    a,
    input  logic signed [ddo_pkg::MUL_W-1:0]    b,
    output logic signed [2*ddo_pkg::MUL_W-1:0]  prod
);
    import ddo_pkg::*;

    logic signed [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/ddo_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddo_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ddo_pkg::DIV_NUM_W-1:0]     num,
    input  logic [ddo_pkg::DIV_DEN_W-1:0]     den,
    output logic                              done,
    output logic [ddo_pkg::DIV_NUM_W-1:0]     quot
);
    import ddo_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] q_reg;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    always_comb
    begin
        trial = {rem_reg, q_reg[DIV_NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            q_reg   <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            q_reg   <= {q_reg[DIV_NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== hw/rtl/ddo_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_cordic: iterative CORDIC rotation
// Reduces a Q4.16 angle to the right half plane, then one micro-rotation
// per cycle gives cosine and sine in Q3.30.
// ----------------------------------------------------------------------------
module ddo_cordic #(
    parameter int ITER = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [20:0]                angle,
    output logic                              done,
    output logic signed [ddo_pkg::CORD_W-1:0] cos_out,
    output logic signed [ddo_pkg::CORD_W-1:0] sin_out
);
    import ddo_pkg::*;

    localparam int IW = $clog2(ITER);

    logic                     busy_reg;
    logic                     done_reg;
    logic                     flip_reg;
    logic [IW-1:0]            i_reg;
    logic signed [CORD_W-1:0] x_reg;
    logic signed [CORD_W-1:0] y_reg;
    logic signed [32:0]       z_reg;
    logic signed [CORD_W-1:0] cos_reg;
    logic signed [CORD_W-1:0] sin_reg;

    logic signed [21:0]       a0, a1, a2, a3, a4, a5;
    logic                     flip_c;
    logic signed [CORD_W-1:0] xs, ys, nx, ny;
    logic signed [32:0]       at, nz;

    always_comb
    begin
        a0 = 22'(angle);
        a1 = (a0 > PI_Q) ? 22'(a0 - TWO_PI_Q) : a0;
        a2 = (a1 > PI_Q) ? 22'(a1 - TWO_PI_Q) : a1;
        a3 = (a2 < -PI_Q) ? 22'(a2 + TWO_PI_Q) : a2;
        a4 = (a3 < -PI_Q) ? 22'(a3 + TWO_PI_Q) : a3;
        flip_c = 1'b0;
        a5 = a4;
        if (a4 > HALF_PI_Q)
        begin
            a5 = 22'(a4 - PI_Q);
            flip_c = 1'b1;
        end
        else if (a4 < -HALF_PI_Q)
        begin
            a5 = 22'(a4 + PI_Q);
            flip_c = 1'b1;
        end
    end

    always_comb
    begin
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = 33'(atan_q30(5'(i_reg)));
        if (z_reg >= 0)
        begin
            nx = x_reg - ys;
            ny = y_reg + xs;
            nz = z_reg - at;
        end
        else
        begin
            nx = x_reg + ys;
            ny = y_reg - xs;
            nz = z_reg + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == IW'(ITER - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORD_W'(CORDIC_INV_GAIN);
            y_reg    <= '0;
            z_reg    <= 33'(a5) <<< 14;
            flip_reg <= flip_c;
        end
        else if (busy_reg)
        begin
            x_reg <= nx;
            y_reg <= ny;
            z_reg <= nz;
            if (i_reg == IW'(ITER - 1))
            begin
                cos_reg <= flip_reg ? -nx : nx;
                sin_reg <= flip_reg ? -ny : ny;
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

// ===== hw/rtl/diff_drive_odometry_integrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_odometry_integrator: differential-drive pose integrator
// Per request: the 59-step speed division and the rotation dominate the
//   work; the gyro states are skipped with the gyro off, and the division
//   is skipped at zero step time.
// Accepts a new request only once the last result is handed on; not ready
//   while busy or while a finished result waits for the output register.
// Reset: pose, held gyro turn, output valid and config clear; the four gains load 16384.
// ----------------------------------------------------------------------------
module diff_drive_odometry_integrator #(
    parameter int CORDIC_ITERATIONS  = 16,
    parameter int POSITION_FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tick_valid,
    output logic            tick_ready,
    input  ddo_pkg::tick_t  tick,
    output logic            pose_valid,
    input  logic            pose_ready,
    output ddo_pkg::pose_t  pose,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [3:0]      cfg_index,
    input  logic [31:0]     cfg_data
);
    import ddo_pkg::*;

    localparam int DIST_SHIFT = 48 - POSITION_FRAC_BITS;
    localparam int SPD_NSH    = (POSITION_FRAC_BITS <= 16) ? 16 - POSITION_FRAC_BITS : 0;
    localparam int SPD_DSH    = (POSITION_FRAC_BITS > 16) ? POSITION_FRAC_BITS - 16 : 0;

    localparam logic [3:0] CFG_BLEND = 4'd0;
    localparam logic [3:0] CFG_IMU   = 4'd1;
    localparam logic [3:0] CFG_LFWD  = 4'd2;
    localparam logic [3:0] CFG_LREV  = 4'd3;
    localparam logic [3:0] CFG_TCCW  = 4'd4;
    localparam logic [3:0] CFG_TCW   = 4'd5;
    localparam logic [3:0] CFG_DSCL  = 4'd6;
    localparam logic [3:0] CFG_TSCL  = 4'd7;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_MAGD   = 5'd1;
    localparam logic [4:0] ST_MAGW   = 5'd2;
    localparam logic [4:0] ST_DLO    = 5'd3;
    localparam logic [4:0] ST_DHI    = 5'd4;
    localparam logic [4:0] ST_DCMB   = 5'd5;
    localparam logic [4:0] ST_WHI    = 5'd6;
    localparam logic [4:0] ST_WCMB   = 5'd7;
    localparam logic [4:0] ST_GYRO   = 5'd8;
    localparam logic [4:0] ST_GWAIT  = 5'd9;
    localparam logic [4:0] ST_BLW    = 5'd10;
    localparam logic [4:0] ST_BLH    = 5'd11;
    localparam logic [4:0] ST_BSUM   = 5'd12;
    localparam logic [4:0] ST_TGAIN  = 5'd13;
    localparam logic [4:0] ST_DGAIN  = 5'd14;
    localparam logic [4:0] ST_ROT    = 5'd15;
    localparam logic [4:0] ST_CWAIT  = 5'd16;
    localparam logic [4:0] ST_XMUL   = 5'd17;
    localparam logic [4:0] ST_YMUL   = 5'd18;
    localparam logic [4:0] ST_SMUL   = 5'd19;
    localparam logic [4:0] ST_SDIV   = 5'd20;
    localparam logic [4:0] ST_DWAIT  = 5'd21;
    localparam logic [4:0] ST_FINISH = 5'd22;
    localparam logic [4:0] ST_GQ     = 5'd23;

    logic [4:0]  state_reg, state_next;

    logic [16:0] blend_weight_reg;
    logic        imu_enable_reg;
    logic [15:0] lin_gain_fwd_reg, lin_gain_rev_reg;
    logic [15:0] turn_gain_ccw_reg, turn_gain_cw_reg;
    logic [31:0] dist_scale_reg, turn_scale_reg;

    logic signed [31:0] pose_x_reg, pose_y_reg;
    logic signed [19:0] heading_reg, hold_reg;
    logic               pose_valid_reg;
    pose_t              out_reg;

    tick_t              tick_reg;
    logic [16:0]        sum_mag_reg, diff_mag_reg;
    logic               sum_neg_reg, diff_neg_reg, gneg_reg;
    logic [36:0]        magd_reg, magw_reg, gmag_reg;
    logic [63:0]        plo_reg;
    logic signed [31:0] dist_reg, speed_reg;
    logic signed [19:0] wheel_reg, turn_pre_reg, turn_reg;
    logic signed [37:0] acc_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod;

    logic                  div_start, div_done;
    logic [DIV_NUM_W-1:0]  div_num, div_quot;
    logic [DIV_DEN_W-1:0]  div_den;

    logic                     cor_start, cor_done;
    logic signed [20:0]       cor_angle;
    logic signed [CORD_W-1:0] cor_cos, cor_sin;

    logic signed [16:0] sum_s, diff_s;
    logic [16:0]        sum_mag_c, diff_mag_c;
    logic [16:0]        w_c, wc_c;
    logic [69:0]        wide, dsh, wsh;
    logic [30:0]        dist_mag_c;
    logic [18:0]        wheel_mag_c;
    logic signed [31:0] dist_raw;
    logic signed [19:0] wheel_raw;
    logic signed [36:0] gprod;
    logic [36:0]        gmag;
    logic [18:0]        gq_c;
    logic signed [38:0] bsum;
    logic signed [35:0] tsh;
    logic signed [19:0] turn_sat;
    logic signed [47:0] dgsh;
    logic signed [31:0] dist_gain;
    logic [31:0]        dist_abs;
    logic signed [38:0] pos_add;
    logic signed [31:0] pos_sat;
    logic signed [20:0] hsum, h1, h2;
    logic signed [31:0] speed_c;
    logic [15:0]        gain_t, gain_d;

    function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
        logic signed [31:0] r;
        if (v > WORD_MAX)
            r = 32'sh7FFFFFFF;
        else if (v < -WORD_MAX - 1)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    always_comb
    begin
        sum_s      = 17'(tick.rpm_left) + 17'(tick.rpm_right);
        diff_s     = 17'(tick.rpm_right) - 17'(tick.rpm_left);
        sum_mag_c  = sum_s[16] ? 17'(-sum_s) : sum_s;
        diff_mag_c = diff_s[16] ? 17'(-diff_s) : diff_s;

        w_c  = (blend_weight_reg > 17'd65536) ? 17'd65536 : blend_weight_reg;
        wc_c = 17'd65536 - w_c;

        wide = {6'd0, plo_reg} + {1'b0, prod[36:0], 32'd0};
        dsh  = wide >> DIST_SHIFT;
        wsh  = wide >> 32;
        dist_mag_c  = (dsh > 70'(WORD_MAX)) ? 31'(WORD_MAX) : dsh[30:0];
        wheel_mag_c = (wsh > 70'(ANGLE_LIMIT)) ? 19'(ANGLE_LIMIT) : wsh[18:0];
        dist_raw  = sum_neg_reg ? -$signed({1'b0, dist_mag_c}) : $signed({1'b0, dist_mag_c});
        wheel_raw = diff_neg_reg ? -$signed({1'b0, wheel_mag_c})
                                 : $signed({1'b0, wheel_mag_c});

        gprod = prod[36:0];
        gmag  = gprod[36] ? 37'(-gprod) : gprod;
        gq_c  = (gmag_reg >= GYRO_SAT_MAG) ? 19'(ANGLE_LIMIT)
                                           : prod[GYRO_RSH+18:GYRO_RSH];

        bsum = 39'(acc_reg) + 39'($signed(prod[37:0]));

        tsh = $signed(prod[35:0]) >>> 14;
        if (tsh > ANGLE_LIMIT)
            turn_sat = 20'(ANGLE_LIMIT);
        else if (tsh < -ANGLE_LIMIT)
            turn_sat = -20'(ANGLE_LIMIT);
        else
            turn_sat = tsh[19:0];

        dgsh = $signed(prod[47:0]) >>> 14;
        if (dgsh > WORD_MAX)
            dist_gain = 32'sh7FFFFFFF;
        else if (dgsh < -WORD_MAX)
            dist_gain = -32'sh7FFFFFFF;
        else
            dist_gain = dgsh[31:0];

        dist_abs = dist_reg[31] ? 32'(-dist_reg) : 32'(dist_reg);
        pos_add  = 39'($signed(prod[67:30]));
        if (state_reg == ST_YMUL)
            pos_add = pos_add + 39'(pose_x_reg);
        else
            pos_add = pos_add + 39'(pose_y_reg);
        pos_sat = sat32(pos_add);

        hsum = 21'(heading_reg) + 21'(turn_reg);
        h1   = (hsum >= TWO_PI_Q) ? 21'(hsum - TWO_PI_Q) : hsum;
        h2   = (h1 <= -TWO_PI_Q) ? 21'(h1 + TWO_PI_Q) : h1;

        if (!dist_reg[31])
            speed_c = (div_quot > DIV_NUM_W'(WORD_MAX)) ? 32'sh7FFFFFFF : div_quot[31:0];
        else
            speed_c = (div_quot > DIV_NUM_W'(64'd2147483648)) ? 32'sh80000000
                                                                : -div_quot[31:0];

        gain_t = turn_pre_reg[19] ? turn_gain_cw_reg : turn_gain_ccw_reg;
        gain_d = dist_reg[31] ? lin_gain_rev_reg : lin_gain_fwd_reg;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MAGD:
            begin
                mul_a = MUL_W'(sum_mag_reg);
                mul_b = MUL_W'(tick_reg.step_time);
            end
            ST_MAGW:
            begin
                mul_a = MUL_W'(diff_mag_reg);
                mul_b = MUL_W'(tick_reg.step_time);
            end
            ST_DLO:
            begin
                mul_a = MUL_W'(magd_reg[31:0]);
                mul_b = MUL_W'(dist_scale_reg);
            end
            ST_DHI:
            begin
                mul_a = MUL_W'(magd_reg[36:32]);
                mul_b = MUL_W'(dist_scale_reg);
            end
            ST_DCMB:
            begin
                mul_a = MUL_W'(magw_reg[31:0]);
                mul_b = MUL_W'(turn_scale_reg);
            end
            ST_WHI:
            begin
                mul_a = MUL_W'(magw_reg[36:32]);
                mul_b = MUL_W'(turn_scale_reg);
            end
            ST_WCMB:
            begin
                mul_a = MUL_W'(tick_reg.step_time);
                mul_b = MUL_W'(tick_reg.gyro_rate);
            end
            ST_GWAIT:
            begin
                mul_a = MUL_W'(gmag_reg[36:2]);
                mul_b = MUL_W'(GYRO_RECIP);
            end
            ST_BLW:
            begin
                mul_a = MUL_W'(w_c);
                mul_b = MUL_W'(wheel_reg);
            end
            ST_BLH:
            begin
                mul_a = MUL_W'(wc_c);
                mul_b = MUL_W'(hold_reg);
            end
            ST_TGAIN:
            begin
                mul_a = MUL_W'(turn_pre_reg);
                mul_b = MUL_W'(gain_t);
            end
            ST_DGAIN:
            begin
                mul_a = MUL_W'(dist_reg);
                mul_b = MUL_W'(gain_d);
            end
            ST_XMUL:
            begin
                mul_a = MUL_W'(dist_reg);
                mul_b = cor_cos;
            end
            ST_YMUL:
            begin
                mul_a = MUL_W'(dist_reg);
                mul_b = cor_sin;
            end
            ST_SMUL:
            begin
                mul_a = MUL_W'(dist_abs);
                mul_b = MUL_W'(SPEED_MUL);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_start = (state_reg == ST_SDIV);
    assign div_num   = DIV_NUM_W'(prod[50:0]) << SPD_NSH;
    assign div_den   = DIV_DEN_W'(tick_reg.step_time) << SPD_DSH;

    assign cor_start = (state_reg == ST_ROT);
    assign cor_angle = 21'(heading_reg) - 21'(turn_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   state_next = tick_valid ? ST_MAGD : ST_IDLE;
            ST_MAGD:   state_next = ST_MAGW;
            ST_MAGW:   state_next = ST_DLO;
            ST_DLO:    state_next = ST_DHI;
            ST_DHI:    state_next = ST_DCMB;
            ST_DCMB:   state_next = ST_WHI;
            ST_WHI:    state_next = ST_WCMB;
            ST_WCMB:   state_next = ST_GYRO;
            ST_GYRO:   state_next = imu_enable_reg ? ST_GWAIT : ST_BLW;
            ST_GWAIT:  state_next = ST_GQ;
            ST_GQ:     state_next = ST_BLW;
            ST_BLW:    state_next = ST_BLH;
            ST_BLH:    state_next = ST_BSUM;
            ST_BSUM:   state_next = ST_TGAIN;
            ST_TGAIN:  state_next = ST_DGAIN;
            ST_DGAIN:  state_next = ST_ROT;
            ST_ROT:    state_next = ST_CWAIT;
            ST_CWAIT:  state_next = cor_done ? ST_XMUL : ST_CWAIT;
            ST_XMUL:   state_next = ST_YMUL;
            ST_YMUL:   state_next = ST_SMUL;
            ST_SMUL:   state_next = (tick_reg.step_time == 20'd0) ? ST_FINISH : ST_SDIV;
            ST_SDIV:   state_next = ST_DWAIT;
            ST_DWAIT:  state_next = div_done ? ST_FINISH : ST_DWAIT;
            ST_FINISH: state_next = (!pose_valid_reg || pose_ready) ? ST_IDLE : ST_FINISH;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            blend_weight_reg  <= '0;
            imu_enable_reg    <= 1'b0;
            lin_gain_fwd_reg  <= 16'd16384;
            lin_gain_rev_reg  <= 16'd16384;
            turn_gain_ccw_reg <= 16'd16384;
            turn_gain_cw_reg  <= 16'd16384;
            dist_scale_reg    <= '0;
            turn_scale_reg    <= '0;
            pose_x_reg        <= '0;
            pose_y_reg        <= '0;
            heading_reg       <= '0;
            hold_reg          <= '0;
            pose_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_BLEND: blend_weight_reg  <= cfg_data[16:0];
                    CFG_IMU:   imu_enable_reg    <= cfg_data[0];
                    CFG_LFWD:  lin_gain_fwd_reg  <= cfg_data[15:0];
                    CFG_LREV:  lin_gain_rev_reg  <= cfg_data[15:0];
                    CFG_TCCW:  turn_gain_ccw_reg <= cfg_data[15:0];
                    CFG_TCW:   turn_gain_cw_reg  <= cfg_data[15:0];
                    CFG_DSCL:  dist_scale_reg    <= cfg_data;
                    CFG_TSCL:  turn_scale_reg    <= cfg_data;
                    default:   ;
                endcase
            end
            if (state_reg == ST_GQ)
                hold_reg <= gneg_reg ? -20'(gq_c) : 20'(gq_c);
            if (state_reg == ST_ROT)
                heading_reg <= h2[19:0];
            if (state_reg == ST_YMUL)
                pose_x_reg <= pos_sat;
            if (state_reg == ST_SMUL)
                pose_y_reg <= pos_sat;
            if ((state_reg == ST_FINISH) && (!pose_valid_reg || pose_ready))
                pose_valid_reg <= 1'b1;
            else if (pose_ready)
                pose_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && tick_valid)
        begin
            tick_reg     <= tick;
            sum_mag_reg  <= sum_mag_c;
            sum_neg_reg  <= sum_s[16];
            diff_mag_reg <= diff_mag_c;
            diff_neg_reg <= diff_s[16];
        end
        if (state_reg == ST_MAGW)
            magd_reg <= prod[36:0];
        if (state_reg == ST_DLO)
            magw_reg <= prod[36:0];
        if ((state_reg == ST_DHI) || (state_reg == ST_WHI))
            plo_reg <= prod[63:0];
        if (state_reg == ST_DCMB)
            dist_reg <= dist_raw;
        if (state_reg == ST_WCMB)
            wheel_reg <= wheel_raw;
        if (state_reg == ST_GYRO)
        begin
            gneg_reg <= gprod[36];
            gmag_reg <= gmag;
        end
        if (state_reg == ST_BLH)
            acc_reg <= prod[37:0];
        if (state_reg == ST_BSUM)
            turn_pre_reg <= bsum[35:16];
        if (state_reg == ST_DGAIN)
            turn_reg <= turn_sat;
        if (state_reg == ST_ROT)
            dist_reg <= dist_gain;
        if (state_reg == ST_SMUL)
            speed_reg <= '0;
        if ((state_reg == ST_DWAIT) && div_done)
            speed_reg <= speed_c;
        if ((state_reg == ST_FINISH) && (!pose_valid_reg || pose_ready))
        begin
            out_reg.pos_x        <= pose_x_reg;
            out_reg.pos_y        <= pose_y_reg;
            out_reg.heading      <= heading_reg;
            out_reg.speed_linear <= speed_reg;
            out_reg.turn_step    <= turn_reg;
            out_reg.stationary   <= (tick_reg.rpm_left == 16'sd0) &&
                                    (tick_reg.rpm_right == 16'sd0);
        end
    end

    ddo_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ddo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    ddo_cordic #(
        .ITER (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    assign tick_ready = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign pose_valid = pose_valid_reg;
    assign pose       = out_reg;

`ifndef SYNTHESIS
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        (heading_reg <= ANGLE_LIMIT) && (heading_reg >= -ANGLE_LIMIT))
        else $error("heading out of range");

    a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_reg <= ANGLE_LIMIT) && (hold_reg >= -ANGLE_LIMIT))
        else $error("held gyro turn out of range");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && tick_ready) |=> (state_reg == ST_MAGD))
        else $error("accepted request did not start");

    a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> (state_reg == ST_CWAIT))
        else $error("rotation finished outside its wait state");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DWAIT))
        else $error("division finished outside its wait state");
`endif

endmodule
